@@ rtl/bfp_pkg.sv @@
// bfp_pkg: shared constants, types and the front-to-back command struct
// for the bilateral filter pixel block. No dependencies.
`default_nettype none
package bfp_pkg;
    localparam int MaxRows    = 64;
    localparam int MaxCols    = 64;
    localparam int MaxWindow  = 7;
    localparam int WeightBits = 16;
    localparam int RowBits    = 6;
    localparam int ColBits    = 6;
    localparam int AddrBits   = RowBits + ColBits;
    localparam int SpDepth    = MaxWindow * MaxWindow;
    localparam int SpBits     = 6;
    localparam int MaxRad     = MaxWindow / 2;
    localparam int TapW       = 2 * WeightBits;      // tap weight width
    localparam int DenW       = TapW + 6;            // up to 49 taps
    localparam int NumW       = DenW + 8;

    typedef enum logic [1:0] {
        OP_WR_PIX = 2'd0,
        OP_QUERY  = 2'd1,
        OP_WR_RNG = 2'd2,
        OP_WR_SP  = 2'd3
    } t_op;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_WIN  = 2'd2;

    typedef struct packed {
        t_op                    op;
        logic [RowBits-1:0]     row;
        logic [ColBits-1:0]     col;
        logic [7:0]             table_index;
        logic [WeightBits-1:0]  data;
        logic                   outside;   // query misses the frame
    } t_cmd;
endpackage
`default_nettype wire

@@ rtl/bfp_front.sv @@
// bfp_front: accepts input beats, flags queries outside the frame and
// pushes commands into a two-entry queue. Depends on bfp_pkg.
`default_nettype none
module bfp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_op,
    input  wire logic [bfp_pkg::RowBits-1:0]   i_row,
    input  wire logic [bfp_pkg::ColBits-1:0]   i_col,
    input  wire logic [7:0]                    i_table_index,
    input  wire logic [bfp_pkg::WeightBits-1:0] i_data,
    input  wire logic [6:0]                    i_rows,
    input  wire logic [6:0]                    i_cols,
    output logic                               o_cmd_valid,
    output bfp_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_cmd_pop
);
    bfp_pkg::t_cmd r_q [2];
    logic          r_rd, r_wr;
    logic [1:0]    r_cnt;
    bfp_pkg::t_cmd w_cmd;
    logic          w_push;

    always_comb begin
        w_cmd.op          = bfp_pkg::t_op'(i_op);
        w_cmd.row         = i_row;
        w_cmd.col         = i_col;
        w_cmd.table_index = i_table_index;
        w_cmd.data        = i_data;
        w_cmd.outside     = ({1'b0, i_row} >= i_rows) || ({1'b0, i_col} >= i_cols);
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_cmd_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_rd == r_wr)) else $error("queue pointers split");
endmodule
`default_nettype wire

@@ rtl/bfp_div.sv @@
// bfp_div: restoring divider, one quotient bit per cycle, with half-up
// rounding of the quotient. Depends on bfp_pkg.
`default_nettype none
module bfp_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bfp_pkg::NumW-1:0]   i_num,
    input  wire logic [bfp_pkg::DenW-1:0]   i_den,
    output logic                            o_done,
    output logic [7:0]                      o_quot
);
    localparam int CntW = $clog2(bfp_pkg::NumW + 1);
    logic [bfp_pkg::NumW-1:0] r_q;
    logic [bfp_pkg::DenW:0]   r_rem;
    logic [bfp_pkg::DenW-1:0] r_den;
    logic [CntW-1:0]          r_cnt;
    logic                     r_busy;
    logic [bfp_pkg::DenW:0]   w_sh;
    logic                     w_ge;
    logic [bfp_pkg::DenW+1:0] w_twice;

    assign w_sh    = {r_rem[bfp_pkg::DenW-1:0], r_q[bfp_pkg::NumW-1]};
    assign w_ge    = w_sh >= {1'b0, r_den};
    assign w_twice = {r_rem, 1'b0};
    assign o_quot  = r_q[7:0] + {7'd0, (w_twice >= {2'b0, r_den})};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[bfp_pkg::NumW-2:0], w_ge};
            r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == CntW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(bfp_pkg::NumW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/bfp_back.sv @@
// bfp_back: executes commands: table/frame writes, and queries via a tap
// walk with a multiply-accumulate pipeline and the divider. Needs bfp_pkg, bfp_div.
`default_nettype none
module bfp_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_valid,
    input  wire bfp_pkg::t_cmd        i_cmd,
    output logic                      o_cmd_pop,
    input  wire logic [6:0]           i_rows,
    input  wire logic [6:0]           i_cols,
    input  wire logic [2:0]           i_win,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [7:0]                o_filtered,
    output logic                      o_zero_weight
);
    localparam int FrameDepth = bfp_pkg::MaxRows * bfp_pkg::MaxCols;
    typedef enum logic [2:0] {
        S_IDLE, S_CENTER, S_TAP, S_DRAIN, S_DIV, S_WAITDIV, S_OUT
    } t_state;

    logic [7:0]                    r_frame [FrameDepth];
    logic [bfp_pkg::WeightBits-1:0] r_rng [256];
    logic [bfp_pkg::WeightBits-1:0] r_sp  [bfp_pkg::SpDepth];

    t_state r_state;
    bfp_pkg::t_cmd r_cmd;
    logic [2:0] r_ky, r_kx, r_rad;
    logic [7:0] r_center;
    logic [7:0] r_pix;
    logic [bfp_pkg::WeightBits-1:0] r_rw, r_sw;
    logic       r_v1, r_v2, r_v3;
    logic [7:0] r_nb2, r_nb3;
    logic [7:0] r_pos_sp;
    logic [bfp_pkg::TapW-1:0] r_w3;
    logic [bfp_pkg::NumW-1:0] r_num;
    logic [bfp_pkg::DenW-1:0] r_den;
    logic [2:0] r_drain;
    logic       r_div_start;
    logic       w_div_done;
    logic [7:0] w_quot;
    logic [bfp_pkg::TapW+7:0] w_prod;

    // tap address and range checks
    logic signed [7:0] w_y, w_x;
    logic       w_in;
    logic [bfp_pkg::AddrBits-1:0] w_addr;
    logic [7:0] w_diff;
    logic [2:0] w_rad, w_side_m1;
    logic       w_last;

    assign w_rad     = (i_win >> 1) > 3'(bfp_pkg::MaxRad) ? 3'(bfp_pkg::MaxRad) : (i_win >> 1);
    assign w_side_m1 = {r_rad[1:0], 1'b0};
    assign w_y = $signed({2'b0, r_cmd.row}) + $signed({5'b0, r_ky}) - $signed({5'b0, r_rad});
    assign w_x = $signed({2'b0, r_cmd.col}) + $signed({5'b0, r_kx}) - $signed({5'b0, r_rad});
    assign w_in = (w_y >= 0) && (w_y < $signed({1'b0, i_rows})) &&
                  (w_x >= 0) && (w_x < $signed({1'b0, i_cols}));
    assign w_addr = {w_y[5:0], w_x[5:0]};
    assign w_last = (r_ky == w_side_m1) && (r_kx == w_side_m1);
    assign w_diff = (r_pix > r_center) ? r_pix - r_center : r_center - r_pix;
    // full-width weight times pixel
    assign w_prod = r_w3 * r_nb3;

    bfp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_num), .i_den(r_den), .o_done(w_div_done), .o_quot(w_quot)
    );

    always_comb o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // memories
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == bfp_pkg::OP_WR_PIX)
            r_frame[{i_cmd.row, i_cmd.col}] <= i_cmd.data[7:0];
        if (o_cmd_pop && i_cmd.op == bfp_pkg::OP_WR_RNG)
            r_rng[i_cmd.table_index] <= i_cmd.data;
        if (o_cmd_pop && i_cmd.op == bfp_pkg::OP_WR_SP &&
            i_cmd.table_index < 8'(bfp_pkg::SpDepth))
            r_sp[i_cmd.table_index[bfp_pkg::SpBits-1:0]] <= i_cmd.data;
        // frame read: center in S_CENTER, taps in S_TAP
        r_pix <= (r_state == S_CENTER) ? r_frame[{r_cmd.row, r_cmd.col}] : r_frame[w_addr];
        r_sw  <= r_sp[r_pos_sp[bfp_pkg::SpBits-1:0]];
        r_rw  <= r_rng[w_diff];
    end

    // tap pipeline: stage1 frame read, stage2 range read, stage3 weight mul
    always_ff @(posedge i_clk) begin
        r_nb2 <= r_pix;
        r_nb3 <= r_nb2;
        r_w3  <= r_rw * r_sw;
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_TAP) && w_in;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (r_state == S_TAP) r_pos_sp <= 8'(r_ky) * 8'(bfp_pkg::MaxWindow) + 8'(r_kx);
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_rad <= w_rad;
            r_ky  <= '0;
            r_kx  <= '0;
            r_num <= '0;
            r_den <= '0;
        end
        if (r_v3) begin
            r_num <= r_num + bfp_pkg::NumW'(w_prod);
            r_den <= r_den + bfp_pkg::DenW'(r_w3);
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_DIV) && (r_den != '0);
            unique case (r_state)
                S_IDLE: if (o_cmd_pop && i_cmd.op == bfp_pkg::OP_QUERY) begin
                    if (i_cmd.outside) begin
                        o_filtered <= 8'd0; o_zero_weight <= 1'b1;
                        o_valid <= 1'b1; r_state <= S_OUT;
                    end else r_state <= S_CENTER;
                end
                S_CENTER: r_state <= S_TAP;
                S_TAP: begin
                    r_center <= (r_ky == 3'd0 && r_kx == 3'd0) ? r_pix : r_center;
                    if (r_kx == w_side_m1) begin
                        r_kx <= '0; r_ky <= r_ky + 1'b1;
                    end else r_kx <= r_kx + 1'b1;
                    if (w_last) begin
                        r_state <= S_DRAIN; r_drain <= 3'd5;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain - 1'b1;
                    if (r_drain == 3'd0) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_den == '0) begin
                        o_filtered <= 8'd0; o_zero_weight <= 1'b1;
                        o_valid <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_state <= S_WAITDIV;
                    end
                end
                S_WAITDIV: if (w_div_done) begin
                    o_filtered <= w_quot; o_zero_weight <= 1'b0;
                    o_valid <= 1'b1; r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/bilateral_filter_pixel.sv @@
// bilateral_filter_pixel: top level; config registers, front queue and back
// engine. Depends on bfp_pkg, bfp_front, bfp_back, bfp_div.
//
//  channel | direction | handshake         | beat
//  in      | input     | i_valid / o_stall | op, row, col, table_index, data
//  out     | output    | o_valid / i_stall | filtered, zero_weight
//  cfg     | input     | i_cfg_valid/o_cfg_ready | index, value
//
// Writes retire when the back engine pops them from the queue.
// A query walks side*side taps and drains the tap pipeline, then passes
// through the bit-serial divider, which computes a 46-bit quotient.
// Reset (synchronous, low) restores 64x64 frame, window 5; stores are unset.
// A stalled result holds in the output register; the two-entry queue
// keeps taking beats meanwhile until it is full.
`default_nettype none
module bilateral_filter_pixel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [5:0]  i_row,
    input  wire logic [5:0]  i_col,
    input  wire logic [7:0]  i_table_index,
    input  wire logic [15:0] i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_filtered,
    output logic             o_zero_weight,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);
    logic [6:0] r_rows, r_cols, w_rows, w_cols;
    logic [2:0] r_win;
    logic          w_cmd_valid, w_pop;
    bfp_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;
    // rows/cols above the store size saturate
    assign w_rows = (r_rows > 7'(bfp_pkg::MaxRows)) ? 7'(bfp_pkg::MaxRows) : r_rows;
    assign w_cols = (r_cols > 7'(bfp_pkg::MaxCols)) ? 7'(bfp_pkg::MaxCols) : r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
            r_win  <= 3'd5;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bfp_pkg::REG_ROWS: r_rows <= i_cfg_data;
                bfp_pkg::REG_COLS: r_cols <= i_cfg_data;
                bfp_pkg::REG_WIN:  r_win  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    bfp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_row(i_row), .i_col(i_col), .i_table_index(i_table_index),
        .i_data(i_data), .i_rows(w_rows), .i_cols(w_cols),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_pop)
    );

    bfp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_pop(w_pop), .i_rows(w_rows), .i_cols(w_cols), .i_win(r_win),
        .o_valid(o_valid), .i_stall(i_stall), .o_filtered(o_filtered),
        .o_zero_weight(o_zero_weight)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_zero_weight && o_valid |-> o_filtered == 8'd0) else $error("flag with data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rows <= 7'd64 && w_cols <= 7'd64) else $error("frame size");
endmodule
`default_nettype wire
